>>> rtl/core/jvm_numeric_conversion_unit_core_macros.svh
// assertion helpers for the conversion core
`ifndef JVM_NUMERIC_CONVERSION_UNIT_CORE_MACROS_SVH
`define JVM_NUMERIC_CONVERSION_UNIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define JNC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define JNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define JNC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define JNC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/jnc_pkg.sv
package jnc_pkg;

   typedef enum logic [3:0] {
      OP_I2L = 4'd0,
      OP_I2F = 4'd1,
      OP_I2D = 4'd2,
      OP_L2I = 4'd3,
      OP_L2F = 4'd4,
      OP_L2D = 4'd5,
      OP_F2I = 4'd6,
      OP_F2L = 4'd7,
      OP_F2D = 4'd8,
      OP_D2I = 4'd9,
      OP_D2L = 4'd10,
      OP_D2F = 4'd11,
      OP_I2B = 4'd12,
      OP_I2C = 4'd13,
      OP_I2S = 4'd14
   } op_type;

   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_TOFP   = 2'd1,
      KIND_NARROW = 2'd2,
      KIND_TOINT  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        wide;
      logic        sign;
      logic [63:0] vec;
      logic [5:0]  rsh;
      logic [11:0] ebase;
   } stage_type;

   localparam logic [63:0] INT_MAX      = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] INT_MIN      = 64'h0000_0000_8000_0000;
   localparam logic [63:0] WIDE_INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] WIDE_INT_MIN = 64'h8000_0000_0000_0000;
   localparam logic [30:0] INFINITY     = 31'h7F80_0000;

   // exponent field base offsets, msb sits at bit 63 after normalising
   localparam logic [11:0] SGL_BASE = 12'd189;
   localparam logic [11:0] DBL_BASE = 12'd1085;

endpackage

>>> rtl/core/jnc_if.sv
interface jnc_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  operation;
   logic [63:0] operand_bits;
   modport source (output valid, operation, operand_bits, input ready);
   modport sink (input valid, operation, operand_bits, output ready);
endinterface

interface jnc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_bits;
   logic        result_is_wide;
   modport source (output valid, result_bits, result_is_wide, input ready);
   modport sink (input valid, result_bits, result_is_wide, output ready);
endinterface

>>> rtl/core/jvm_numeric_conversion_unit_core.sv
// JVM primitive conversion unit (i2l .. i2s, fifteen opcodes)
// req channel: valid/ready with operation and the raw operand_bits; an item
// moves when valid and ready are both high. 32-bit sources use the low half.
// rsp channel: valid/ready with result_bits and result_is_wide; narrow results
// sit in the low 32 bits with the upper half zero.
// four register stages: unpack and special cases, leading-zero count,
// alignment shift, then rounding and packing into the output register.
// an accepted item passes the s1, s2 and s3 registers into the output register,
// where rsp.valid rises; one item per cycle is taken and delivered while the
// receiver keeps ready high.
// the whole pipe advances together: while rsp.valid is high and rsp.ready is
// low, req.ready drops and every stage holds its item.
// reset (synchronous, active high) clears the stage valid bits only; the
// block is ready in the first cycle after reset.
// floating-point to integer results truncate and saturate, NaN gives zero;
// integer to floating-point and double to float round to nearest even.
`include "jvm_numeric_conversion_unit_core_macros.svh"
module jvm_numeric_conversion_unit_core
   import jnc_pkg::*;
(
   input logic      clock,
   input logic      reset,
   jnc_req_if.sink  req,
   jnc_rsp_if.source rsp
);

   logic      advance;
   logic      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   stage_type s1_ff, s2_ff, s3_ff, s1_in, s2_in, s3_in;
   logic [63:0] out_bits_ff, out_bits_in;
   logic        out_wide_ff;

   assign advance   = !s4_valid_ff || rsp.ready;
   assign req.ready = advance;

   // stage 1: unpack
   logic [31:0] lo, imag;
   logic [63:0] v, lmag;
   logic [7:0]  fex;
   logic [22:0] ffr;
   logic [10:0] dex, dd;
   logic [51:0] dfr;
   logic        fs, ds;

   always_comb begin
      v    = req.operand_bits;
      lo   = v[31:0];
      imag = lo[31] ? (32'd0 - lo) : lo;
      lmag = v[63] ? (64'd0 - v) : v;
      fs   = lo[31];
      fex  = lo[30:23];
      ffr  = lo[22:0];
      ds   = v[63];
      dex  = v[62:52];
      dfr  = v[51:0];
      dd   = 11'd897 - dex;
      s1_in       = '0;
      s1_in.kind  = KIND_DIRECT;
      case (op_type'(req.operation))
         OP_I2L: begin
            s1_in.vec  = {{32{lo[31]}}, lo};
            s1_in.wide = 1'b1;
         end
         OP_L2I: s1_in.vec = {32'd0, lo};
         OP_I2B: s1_in.vec = {32'd0, {24{v[7]}}, v[7:0]};
         OP_I2C: s1_in.vec = {48'd0, v[15:0]};
         OP_I2S: s1_in.vec = {32'd0, {16{v[15]}}, v[15:0]};
         OP_I2F, OP_I2D: begin
            s1_in.wide  = (req.operation == OP_I2D);
            s1_in.sign  = lo[31];
            s1_in.vec   = {32'd0, imag};
            s1_in.ebase = s1_in.wide ? DBL_BASE : SGL_BASE;
            if (imag != 32'd0) begin
               s1_in.kind = KIND_TOFP;
            end else begin
               s1_in.vec = '0;
            end
         end
         OP_L2F, OP_L2D: begin
            s1_in.wide  = (req.operation == OP_L2D);
            s1_in.sign  = v[63];
            s1_in.vec   = lmag;
            s1_in.ebase = s1_in.wide ? DBL_BASE : SGL_BASE;
            if (v != 64'd0) begin
               s1_in.kind = KIND_TOFP;
            end
         end
         OP_F2I, OP_F2L: begin
            s1_in.wide = (req.operation == OP_F2L);
            s1_in.sign = fs;
            if (fex == 8'd255 && ffr != 23'd0) begin
               s1_in.vec = '0;
            end else if (fex >= (s1_in.wide ? 8'd190 : 8'd158)) begin
               if (s1_in.wide) s1_in.vec = fs ? WIDE_INT_MIN : WIDE_INT_MAX;
               else            s1_in.vec = fs ? INT_MIN : INT_MAX;
            end else if (fex < 8'd127) begin
               s1_in.vec = '0;
            end else begin
               s1_in.kind = KIND_TOINT;
               s1_in.vec  = {1'b1, ffr, 40'd0};
               s1_in.rsh  = 6'(8'd190 - fex);
            end
         end
         OP_D2I, OP_D2L: begin
            s1_in.wide = (req.operation == OP_D2L);
            s1_in.sign = ds;
            if (dex == 11'h7FF && dfr != 52'd0) begin
               s1_in.vec = '0;
            end else if (dex >= (s1_in.wide ? 11'd1086 : 11'd1054)) begin
               if (s1_in.wide) s1_in.vec = ds ? WIDE_INT_MIN : WIDE_INT_MAX;
               else            s1_in.vec = ds ? INT_MIN : INT_MAX;
            end else if (dex < 11'd1023) begin
               s1_in.vec = '0;
            end else begin
               s1_in.kind = KIND_TOINT;
               s1_in.vec  = {1'b1, dfr, 11'd0};
               s1_in.rsh  = 6'(11'd1086 - dex);
            end
         end
         OP_F2D: begin
            s1_in.wide = 1'b1;
            s1_in.sign = fs;
            if (fex == 8'd255) begin
               s1_in.vec = {fs, 11'h7FF, 52'd0};
               if (ffr != 23'd0) begin
                  s1_in.vec[51:29] = ffr;
                  s1_in.vec[51]    = 1'b1;
               end
            end else if (fex == 8'd0 && ffr == 23'd0) begin
               s1_in.vec = {fs, 63'd0};
            end else begin
               s1_in.kind  = KIND_TOFP;
               s1_in.vec   = {40'd0, (fex != 8'd0), ffr};
               s1_in.ebase = (fex == 8'd0) ? 12'd936 : (12'(fex) + 12'd935);
            end
         end
         OP_D2F: begin
            s1_in.sign = ds;
            if (dex == 11'h7FF) begin
               s1_in.vec = {32'd0, ds, INFINITY};
               if (dfr != 52'd0) begin
                  s1_in.vec[22:0] = dfr[51:29];
                  s1_in.vec[22]   = 1'b1;
               end
            end else if (dex == 11'd0) begin
               s1_in.vec = {32'd0, ds, 31'd0};
            end else if (dex > 11'd1150) begin
               s1_in.vec = {32'd0, ds, INFINITY};
            end else begin
               s1_in.kind = KIND_NARROW;
               s1_in.vec  = {1'b1, dfr, 11'd0};
               if (dex >= 11'd897) begin
                  s1_in.ebase = 12'(dex - 11'd897);
               end else begin
                  s1_in.rsh = (dd > 11'd63) ? 6'd63 : dd[5:0];
               end
            end
         end
         default: s1_in.vec = '0;
      endcase
   end

   // stage 2: leading-zero count for the normalising shift
   logic [5:0] lz;
   always_comb begin
      lz = '0;
      for (int i = 0; i < 64; i++) begin
         if (s1_ff.vec[i]) lz = 6'(63 - i);
      end
      s2_in = s1_ff;
      if (s1_ff.kind == KIND_TOFP) begin
         s2_in.rsh   = lz;
         s2_in.ebase = s1_ff.ebase - 12'(lz);
      end
   end

   // stage 3: alignment shift, lost bits jammed into bit 0 for d2f
   logic [63:0] lost_mask;
   always_comb begin
      lost_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << s2_ff.rsh);
      s3_in = s2_ff;
      case (s2_ff.kind)
         KIND_TOFP:   s3_in.vec = s2_ff.vec << s2_ff.rsh;
         KIND_NARROW: s3_in.vec = (s2_ff.vec >> s2_ff.rsh)
                                  | {63'd0, |(s2_ff.vec & lost_mask)};
         KIND_TOINT:  s3_in.vec = s2_ff.vec >> s2_ff.rsh;
         default:     s3_in.vec = s2_ff.vec;
      endcase
   end

   // stage 4: round to nearest even and pack, or negate
   logic [24:0] ks;
   logic [53:0] kd;
   logic [31:0] sum32;
   logic [63:0] sum64, raw;
   always_comb begin
      ks    = {1'b0, s3_ff.vec[63:40]}
              + 25'(s3_ff.vec[39] & ((|s3_ff.vec[38:0]) | s3_ff.vec[40]));
      kd    = {1'b0, s3_ff.vec[63:11]}
              + 54'(s3_ff.vec[10] & ((|s3_ff.vec[9:0]) | s3_ff.vec[11]));
      // a rounding carry out of the mantissa bumps the exponent by itself
      sum32 = (32'(s3_ff.ebase) << 23) + 32'(ks);
      sum64 = (64'(s3_ff.ebase) << 52) + 64'(kd);
      case (s3_ff.kind)
         KIND_TOFP, KIND_NARROW: begin
            if (s3_ff.wide) raw = {s3_ff.sign, sum64[62:0]};
            else            raw = {32'd0, s3_ff.sign, sum32[30:0]};
         end
         KIND_TOINT: raw = s3_ff.sign ? (64'd0 - s3_ff.vec) : s3_ff.vec;
         default:    raw = s3_ff.vec;
      endcase
      out_bits_in = s3_ff.wide ? raw : {32'd0, raw[31:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_ff       <= s3_in;
         out_bits_ff <= out_bits_in;
         out_wide_ff <= s3_ff.wide;
      end
   end

   assign rsp.valid          = s4_valid_ff;
   assign rsp.result_bits    = out_bits_ff;
   assign rsp.result_is_wide = out_wide_ff;

   `JNC_ASSERT_IMPL(a_narrow_upper_zero, clock, reset,
      rsp.valid && !rsp.result_is_wide, rsp.result_bits[63:32] == 32'd0)
   `JNC_ASSERT_NEXT(a_stage_moves, clock, reset,
      s2_valid_ff && advance, s3_valid_ff)
   `JNC_ASSERT_NEXT(a_stall_holds, clock, reset,
      !advance, $stable(s3_ff) && $stable(s1_valid_ff))

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
module tb;
   import jnc_pkg::*;

   localparam logic [3:0] OP_UNUSED = 4'd15;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct {
      logic [3:0]  op;
      logic [63:0] operand;
      logic [63:0] bits;
      logic        wide;
   } conversion_type;

   logic clock;
   logic reset;

   jnc_req_if req_if ();
   jnc_rsp_if rsp_if ();

   jvm_numeric_conversion_unit_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   conversion_type expected_conversions[$];
   int          mismatches;
   int          items_sent;
   int          results_seen;
   int          idle_cycles;
   bit          no_gaps;
   int          hold_epoch;
   int          seen_epoch;
   int          hold_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- conversion predictor ----------------

   function automatic int top_bit(logic [63:0] v);
      int p;
      p = 0;
      while (p < 63 && (v >> (p + 1)) != 0)
         p++;
      return p;
   endfunction

   function automatic logic [63:0] int_to_fp(bit neg, logic [63:0] mag, int mbits,
                                             int bias, int total);
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      int          e;
      int          sh;
      if (mag == 0)
         return 64'd0;
      e = top_bit(mag);
      if (e <= mbits) begin
         keep = mag << (mbits - e);
      end else begin
         sh = e - mbits;
         rem = mag & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         keep = mag >> sh;
         if (rem > half || (rem == half && keep[0]))
            keep++;
         if (keep == (64'd2 << mbits)) begin
            keep = keep >> 1;
            e++;
         end
      end
      return (neg ? (64'd1 << (total - 1)) : 64'd0) | (64'(e + bias) << mbits)
             | (keep & ((64'd1 << mbits) - 1));
   endfunction

   // truncating, saturating, NaN gives zero
   function automatic logic [63:0] fp_to_int(logic [63:0] x, int mbits, int ebits, int n);
      int          e;
      bit          neg;
      logic [63:0] emax;
      logic [63:0] ex;
      logic [63:0] frac;
      logic [63:0] nmask;
      logic [63:0] vmax;
      logic [63:0] vmin;
      logic [63:0] m;
      logic [63:0] mag;
      neg = x[ebits + mbits];
      emax = (64'd1 << ebits) - 1;
      ex = (x >> mbits) & emax;
      frac = x & ((64'd1 << mbits) - 1);
      nmask = (n == 64) ? '1 : ((64'd1 << n) - 1);
      vmax = (64'd1 << (n - 1)) - 1;
      vmin = 64'd1 << (n - 1);
      if (ex == emax)
         return (frac != 0) ? 64'd0 : (neg ? vmin : vmax);
      if (ex == 0)
         return 64'd0;
      e = int'(ex) - int'(emax >> 1);
      if (e < 0)
         return 64'd0;
      if (e >= n - 1)
         return neg ? vmin : vmax;
      m = frac | (64'd1 << mbits);
      mag = (e >= mbits) ? (m << (e - mbits)) : (m >> (mbits - e));
      return (neg ? (64'd0 - mag) : mag) & nmask;
   endfunction

   function automatic logic [63:0] float_to_double(logic [31:0] x);
      logic [63:0] s;
      logic [63:0] frac;
      logic [7:0]  ex;
      int          p;
      s = {x[31], 63'd0};
      ex = x[30:23];
      frac = {41'd0, x[22:0]};
      if (ex == 8'hFF) begin
         if (frac == 0)
            return s | (64'h7FF << 52);
         return s | (64'h7FF << 52) | (64'd1 << 51) | (frac << 29);
      end
      if (ex == 0) begin
         if (frac == 0)
            return s;
         p = top_bit(frac);
         return s | (64'(p - 149 + 1023) << 52) | ((frac << (52 - p)) & ((64'd1 << 52) - 1));
      end
      return s | (64'(int'(ex) - 127 + 1023) << 52) | (frac << 29);
   endfunction

   function automatic logic [31:0] double_to_float(logic [63:0] x);
      logic [31:0] s;
      logic [63:0] frac;
      logic [63:0] m;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] keep;
      int          ex;
      int          e;
      int          sh;
      s = {x[63], 31'd0};
      ex = int'(x[62:52]);
      frac = x & ((64'd1 << 52) - 1);
      if (ex == 'h7FF) begin
         if (frac == 0)
            return s | 32'h7F80_0000;
         return s | 32'h7FC0_0000 | 32'(frac >> 29);
      end
      if (ex == 0)
         return s;
      e = ex - 1023;
      if (e > 127)
         return s | 32'h7F80_0000;
      m = frac | (64'd1 << 52);
      if (e >= -126) begin
         rem = m & ((64'd1 << 29) - 1);
         half = 64'd1 << 28;
         keep = m >> 29;
         if (rem > half || (rem == half && keep[0]))
            keep++;
         if (keep == (64'd1 << 24)) begin
            keep = keep >> 1;
            e++;
         end
         if (e > 127)
            return s | 32'h7F80_0000;
         return s | (32'(e + 127) << 23) | 32'(keep & 64'h7F_FFFF);
      end
      // subnormal result
      sh = -(e + 97);
      if (sh > 60)
         return s;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      keep = m >> sh;
      if (rem > half || (rem == half && keep[0]))
         keep++;
      return s | 32'(keep);
   endfunction

   function automatic conversion_type convert(logic [3:0] op, logic [63:0] v);
      conversion_type c;
      logic [63:0] lo;
      logic [63:0] imag;
      logic [63:0] lmag;
      bit          ineg;
      bit          lneg;
      lo = {32'd0, v[31:0]};
      ineg = v[31];
      imag = ineg ? {32'd0, 32'd0 - v[31:0]} : lo;
      lneg = v[63];
      lmag = lneg ? (64'd0 - v) : v;
      c.op = op;
      c.operand = v;
      c.bits = 64'd0;
      c.wide = 1'b0;
      if (op == OP_UNUSED) begin
         c.bits = 64'd0;
      end else begin
         case (op_type'(op))
            OP_I2L: begin c.bits = {{32{v[31]}}, v[31:0]}; c.wide = 1'b1; end
            OP_I2F: c.bits = int_to_fp(ineg, imag, 23, 127, 32);
            OP_I2D: begin c.bits = int_to_fp(ineg, imag, 52, 1023, 64); c.wide = 1'b1; end
            OP_L2I: c.bits = lo;
            OP_L2F: c.bits = int_to_fp(lneg, lmag, 23, 127, 32);
            OP_L2D: begin c.bits = int_to_fp(lneg, lmag, 52, 1023, 64); c.wide = 1'b1; end
            OP_F2I: c.bits = fp_to_int(lo, 23, 8, 32);
            OP_F2L: begin c.bits = fp_to_int(lo, 23, 8, 64); c.wide = 1'b1; end
            OP_F2D: begin c.bits = float_to_double(v[31:0]); c.wide = 1'b1; end
            OP_D2I: c.bits = fp_to_int(v, 52, 11, 32);
            OP_D2L: begin c.bits = fp_to_int(v, 52, 11, 64); c.wide = 1'b1; end
            OP_D2F: c.bits = {32'd0, double_to_float(v)};
            OP_I2B: c.bits = {32'd0, {24{v[7]}}, v[7:0]};
            OP_I2C: c.bits = {48'd0, v[15:0]};
            OP_I2S: c.bits = {32'd0, {16{v[15]}}, v[15:0]};
            default: c.bits = 64'd0;
         endcase
      end
      if (!c.wide)
         c.bits[63:32] = 32'd0;
      return c;
   endfunction

   // ---------------- sender ----------------

   function automatic int pick_gap();
      int r;
      if (no_gaps)
         return 0;
      r = $urandom_range(0, 9);
      if (r < 6)
         return 0;
      if (r < 9)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   task automatic send_item(logic [3:0] op, logic [63:0] operand);
      int gap;
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.operand_bits <= operand;
      do
         @(posedge clock);
      while (!req_if.ready);
      expected_conversions.push_back(convert(op, operand));
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // operands biased towards the interesting corners of each conversion
   function automatic logic [63:0] pick_operand();
      logic [63:0] v;
      logic [63:0] fexp;
      logic [63:0] dexp;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1: ;
         2: v = {{32{v[63]}}, v[31:0]} >> $urandom_range(0, 62);
         3: begin
            // floats around the integer limits and the unit
            fexp = 64'($urandom_range(100, 200));
            v[30:23] = fexp[7:0];
         end
         4: begin
            dexp = 64'($urandom_range(950, 1100));
            v[62:52] = dexp[10:0];
         end
         5: begin
            // doubles near the float subnormal and overflow edges
            dexp = ($urandom_range(0, 1) != 0) ? 64'($urandom_range(840, 900))
                                                : 64'($urandom_range(1140, 1160));
            v[62:52] = dexp[10:0];
         end
         6: begin
            v[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            v[62:52] = ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'h000;
            if ($urandom_range(0, 2) == 0) begin
               v[22:0] = 23'd0;
               v[51:0] = 52'd0;
            end
         end
         7: begin
            // tie patterns for rounding
            v[28:0] = {1'b1, 28'd0};
            v[10:0] = {1'b1, 10'd0};
         end
         default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      return v;
   endfunction

   // ---------------- receiver, checker, watchdog ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         seen_epoch <= 0;
         hold_left <= 0;
      end else if (seen_epoch != hold_epoch) begin
         seen_epoch <= hold_epoch;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (no_gaps) begin
         rsp_if.ready <= 1'b1;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2: rsp_if.ready <= 1'b0;
            3: begin
               hold_left <= $urandom_range(4, 25);
               rsp_if.ready <= 1'b0;
            end
            default: rsp_if.ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      conversion_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (expected_conversions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: bits %h wide %b", rsp_if.result_bits,
                        rsp_if.result_is_wide);
         end else begin
            want = expected_conversions.pop_front();
            if (rsp_if.result_bits !== want.bits || rsp_if.result_is_wide !== want.wide) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("op %0d operand %h: expected %h wide %b, got %h wide %b",
                           want.op, want.operand, want.bits, want.wide,
                           rsp_if.result_bits, rsp_if.result_is_wide);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- tests ----------------

   task automatic test_directed();
      send_item(OP_I2L, 64'hFFFF_FFFF_8000_0000);
      send_item(OP_I2L, 64'h1234_5678_7FFF_FFFF);
      send_item(OP_I2F, 64'h0000_0000_7FFF_FFFF);
      send_item(OP_I2F, 64'h0000_0000_8000_0000);
      send_item(OP_I2F, 64'h0000_0000_0100_0003);
      send_item(OP_I2D, 64'hFFFF_FFFF_8000_0000);
      send_item(OP_L2I, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_L2F, 64'h8000_0000_0000_0000);
      send_item(OP_L2D, 64'h7FFF_FFFF_FFFF_FFFF);
      send_item(OP_L2D, 64'h0000_0000_0000_0000);
      send_item(OP_F2I, 64'h0000_0000_7FC0_0000);
      send_item(OP_F2I, 64'h0000_0000_CF00_0001);
      send_item(OP_F2L, 64'h0000_0000_FF80_0000);
      send_item(OP_F2L, 64'h0000_0000_3F7F_FFFF);
      send_item(OP_F2D, 64'h0000_0000_FFC1_2345);
      send_item(OP_F2D, 64'h0000_0000_8000_0001);
      send_item(OP_D2I, 64'h41E0_0000_0000_0000);
      send_item(OP_D2L, 64'hFFF0_0000_0000_0000);
      send_item(OP_D2L, 64'h7FF8_0000_0000_0001);
      send_item(OP_D2F, 64'h47EF_FFFF_F000_0000);
      send_item(OP_D2F, 64'h3690_0000_0000_0001);
      send_item(OP_D2F, 64'h8000_0000_0000_0000);
      send_item(OP_I2B, 64'h0000_0000_0000_0080);
      send_item(OP_I2C, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_I2S, 64'h0000_0000_0000_8000);
      send_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0)
            no_gaps = ($urandom_range(0, 3) == 0);
         send_item(4'($urandom_range(0, 15)), pick_operand());
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_epoch++;
      no_gaps = 1'b1;
      for (int i = 0; i < 30; i++)
         send_item(4'($urandom_range(0, 15)), pick_operand());
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.operation = 4'd0;
      req_if.operand_bits = 64'd0;
      rsp_if.ready = 1'b0;
      mismatches = 0;
      items_sent = 0;
      results_seen = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      hold_epoch = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(500);
      test_backpressure();
      test_random(500);
      req_if.valid <= 1'b0;

      while (expected_conversions.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d conversions sent over all sixteen opcode values, %0d results checked",
               items_sent, results_seen);
      $display("covered specials, rounding ties, saturation and a long output stall");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/jnc_pkg.sv
rtl/core/jnc_if.sv
rtl/core/jvm_numeric_conversion_unit_core.sv
test/tb.sv
